// ----- sv/spiking_neuron_group_update_macros.svh -----
// Assertion macros for the neuron bank update block.
// Included by the RTL files that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef SPIKING_NEURON_GROUP_UPDATE_MACROS_SVH
`define SPIKING_NEURON_GROUP_UPDATE_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define SNU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Condition must never be true outside reset.
`define SNU_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define SNU_ASSERT(lbl, prop, msg)
`define SNU_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ----- sv/snu_pkg.sv -----
// Shared constants, types and saturation helper for the neuron bank update.
// No dependencies; imported by snu_cell, snu_update and the top level.
package snu_pkg;

  localparam int unsigned NEURON_COUNT = 64;
  localparam int unsigned MASK_W       = 64;
  localparam int unsigned Q_W          = 32;
  localparam int unsigned DT_W         = 20;
  localparam int unsigned FRAC_W       = 16;
  localparam int unsigned PROD1_W      = 2 * Q_W;
  localparam int unsigned PROD2_W      = Q_W + DT_W + 1;
  localparam int unsigned PADDR_W      = 3;
  localparam int unsigned PDATA_W      = 32;

  // Pass counter runs over the bank plus the two pipeline stages
  localparam int unsigned CNT_W = $clog2(NEURON_COUNT + 2);
  localparam logic [CNT_W-1:0] READ_CNT = CNT_W'(NEURON_COUNT);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NEURON_COUNT + 1);

  typedef logic signed [Q_W-1:0] q_t;

  localparam q_t Q_MAX = 32'sh7FFF_FFFF;
  localparam q_t Q_MIN = 32'sh8000_0000;
  localparam logic signed [63:0] QMAX64 = 64'(Q_MAX);
  localparam logic signed [63:0] QMIN64 = 64'(Q_MIN);

  localparam q_t THRESH_RST = 32'sh0001_0000;
  localparam q_t GAIN_RST   = 32'sh0001_0000;

  typedef enum logic {
    OP_STEP  = 1'b0,
    OP_SPIKE = 1'b1
  } op_e;

  typedef enum logic {
    REG_THRESH = 1'b0,
    REG_GAIN   = 1'b1
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_POST
  } state_e;

  // Neuron entering the update pipeline
  typedef struct packed {
    logic valid;
    logic sel;
  } slot_t;

  // Status of the neuron leaving the update pipeline
  typedef struct packed {
    logic valid;
    logic fire;
  } res_t;

  // Operands held for the whole pass
  typedef struct packed {
    op_e             op;
    logic [DT_W-1:0] dt;
    q_t              weight;
    q_t              thresh;
    q_t              gain;
  } oper_t;

  // Clamp a wide signed value to the Q16.16 range
  function automatic q_t sat_q(input logic signed [63:0] x);
    q_t r;
    if (x > QMAX64) begin
      r = Q_MAX;
    end else if (x < QMIN64) begin
      r = Q_MIN;
    end else begin
      r = x[Q_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- sv/snu_cell.sv -----
// One link of the potential ring: holds a single Q16.16 membrane potential.
// Depends on snu_pkg for the potential type.
module snu_cell (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         shift_i,
  input  snu_pkg::q_t  d_i,
  output snu_pkg::q_t  q_o
);
  import snu_pkg::*;

  q_t pot_q;

  // Take the neighbor's value whenever the ring advances
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pot_q <= '0;
    end else if (shift_i) begin
      pot_q <= d_i;
    end
  end

  assign q_o = pot_q;

endmodule

// ----- sv/snu_update.sv -----
// Shared update pipeline: Euler step or spike add for one neuron per cycle.
// Depends on snu_pkg; two register stages, one multiplier in each.
module snu_update (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  snu_pkg::slot_t slot_i,
  input  snu_pkg::q_t    pot_i,
  input  snu_pkg::oper_t oper_i,
  output snu_pkg::res_t  res_o,
  output snu_pkg::q_t    pot_o
);
  import snu_pkg::*;

  logic                        valid1_q, valid2_q;
  logic                        sel1_q, sel2_q;
  q_t                          p1_q, p2_q;
  logic signed [PROD1_W-1:0]   prod1_d, prod1_q;
  logic signed [PROD2_W-1:0]   prod2_d, prod2_q;
  logic signed [DT_W:0]        dt_s;
  logic signed [PROD2_W-1:0]   inc;
  q_t                          deriv;
  q_t                          step_p;
  q_t                          spike_p;
  logic                        fire;

  // Stage 1: gain * p, Q32.32
  assign prod1_d = oper_i.gain * pot_i;

  // Stage 2: saturated derivative times step length
  assign deriv   = sat_q(prod1_q >>> FRAC_W);
  assign dt_s    = $signed({1'b0, oper_i.dt});
  assign prod2_d = deriv * dt_s;

  // Stage 3: add increment, clamp, threshold; or spike add
  assign inc     = prod2_q >>> FRAC_W;
  assign step_p  = sat_q(64'(p2_q) + 64'(inc));
  assign spike_p = sat_q(64'(p2_q) + 64'(oper_i.weight));
  assign fire    = (oper_i.op == OP_STEP) && (step_p > oper_i.thresh);

  always_comb begin
    unique case (oper_i.op)
      OP_STEP:  pot_o = fire ? '0 : step_p;
      OP_SPIKE: pot_o = sel2_q ? spike_p : p2_q;
      default:  pot_o = p2_q;
    endcase
  end

  assign res_o.valid = valid2_q;
  assign res_o.fire  = valid2_q && fire;

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else begin
      valid1_q <= slot_i.valid;
      valid2_q <= valid1_q;
    end
  end

  // Stage data
  always_ff @(posedge clk_i) begin
    p1_q    <= pot_i;
    sel1_q  <= slot_i.sel;
    prod1_q <= prod1_d;
    p2_q    <= p1_q;
    sel2_q  <= sel1_q;
    prod2_q <= prod2_d;
  end

endmodule

// ----- sv/spiking_neuron_group_update.sv -----
// Top level of the integrate-and-fire neuron bank: ring of potential cells,
// shared update pipeline, pass control, APB registers. Uses snu_pkg, snu_cell, snu_update.
//
//  Channel   Handshake                 Payload
//  --------  ------------------------  ------------------------------------------------
//  in        in_valid_i / in_ready_o   operation_i, time_delta_i, target_mask_i, spike_weight_i
//  out       out_valid_o / out_ready_i fire_mask_o (time step beats only)
//  cfg       psel/penable/pwrite       paddr, pwdata, prdata (0: threshold, 4: gain)
//
// An item runs one pass around the 64-cell ring, one neuron per cycle through the
// shared multiply pipeline, plus two stages of fill.
// A time step then passes through ST_POST to hand its fire mask to the output register.
// in_ready_o stays low until the block returns to idle, so items do not overlap.
// The output register frees the block while a fire mask waits; a new time step
// stalls at its end only if the previous mask is still not taken.
// Reset clears all potentials at once and loads both registers with 1.0.
module spiking_neuron_group_update (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Input items
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 operation_i,
  input  logic [snu_pkg::DT_W-1:0]             time_delta_i,
  input  logic [snu_pkg::MASK_W-1:0]           target_mask_i,
  input  logic signed [snu_pkg::Q_W-1:0]       spike_weight_i,
  // Result items
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [snu_pkg::MASK_W-1:0]           fire_mask_o,
  // Configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [snu_pkg::PADDR_W-1:0]          paddr,
  input  logic [snu_pkg::PDATA_W-1:0]          pwdata,
  output logic [snu_pkg::PDATA_W-1:0]          prdata,
  output logic                                 pready
);
  import snu_pkg::*;

  `include "spiking_neuron_group_update_macros.svh"

  state_e                   state_q, state_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic                     out_valid_q, out_valid_d;
  logic [MASK_W-1:0]        fire_mask_q;
  logic [NEURON_COUNT-1:0]  fire_acc_q;
  logic [NEURON_COUNT-1:0]  tmask_q;
  op_e                      op_q;
  logic [DT_W-1:0]          dt_q;
  q_t                       weight_q;
  q_t                       thresh_q, gain_q;

  logic   accept;
  logic   shift;
  logic   load_out;
  logic   cfg_wr;
  reg_e   cfg_sel;
  slot_t  slot;
  oper_t  oper;
  res_t   res;
  q_t     upd_pot;
  q_t     pot [NEURON_COUNT];

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign shift      = (state_q == ST_RUN);

  // Potential ring: cell 0 feeds the pipeline, the result enters the last cell
  for (genvar i = 0; i < NEURON_COUNT; i++) begin : g_ring
    if (i == NEURON_COUNT - 1) begin : g_tail
      snu_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift),
        .d_i     (upd_pot),
        .q_o     (pot[i])
      );
    end else begin : g_body
      snu_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift),
        .d_i     (pot[i+1]),
        .q_o     (pot[i])
      );
    end
  end

  // Shared update pipeline
  assign slot.valid   = shift && (cnt_q < READ_CNT);
  assign slot.sel     = tmask_q[0];
  assign oper.op      = op_q;
  assign oper.dt      = dt_q;
  assign oper.weight  = weight_q;
  assign oper.thresh  = thresh_q;
  assign oper.gain    = gain_q;

  snu_update u_update (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .slot_i (slot),
    .pot_i  (pot[0]),
    .oper_i (oper),
    .res_o  (res),
    .pot_o  (upd_pot)
  );

  // Pass control
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    load_out = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_RUN;
          cnt_d   = '0;
        end
      end
      ST_RUN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LAST_CNT) begin
          state_d = (op_q == OP_STEP) ? ST_POST : ST_IDLE;
        end
      end
      ST_POST: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = load_out || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Item operands, target mask and fire mask collection
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q       <= op_e'(operation_i);
      dt_q       <= time_delta_i;
      weight_q   <= spike_weight_i;
      tmask_q    <= target_mask_i[NEURON_COUNT-1:0];
      fire_acc_q <= '0;
    end else begin
      if (slot.valid) begin
        tmask_q <= tmask_q >> 1;
      end
      if (res.valid) begin
        fire_acc_q <= (fire_acc_q >> 1)
                    | (NEURON_COUNT'(res.fire) << (NEURON_COUNT - 1));
      end
    end
    if (load_out) begin
      fire_mask_q <= MASK_W'(fire_acc_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign fire_mask_o = fire_mask_q;

  // Configuration registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RST;
      gain_q   <= GAIN_RST;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_THRESH: thresh_q <= pwdata;
        REG_GAIN:   gain_q   <= pwdata;
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_THRESH: prdata = thresh_q;
      REG_GAIN:   prdata = gain_q;
      default:    prdata = '0;
    endcase
  end

  // Checks
  `SNU_ASSERT(a_accept_starts_pass, accept |=> (state_q == ST_RUN) && (cnt_q == '0), "accepted beat did not start a pass")
  `SNU_ASSERT(a_cnt_bound, (state_q == ST_RUN) |-> (cnt_q <= LAST_CNT), "pass counter ran past the ring")
  `SNU_ASSERT(a_post_only_step, (state_q == ST_POST) |-> (op_q == OP_STEP), "spike beat tried to deliver a fire mask")
  `SNU_ASSERT_NEVER(a_res_outside_pass, res.valid && (state_q != ST_RUN), "pipeline result outside a pass")
  `SNU_ASSERT(a_mask_high_clear, out_valid_o |-> ((fire_mask_o >> NEURON_COUNT) == '0), "fire bit beyond the bank")

endmodule
